/* hdl/mbdlp_pkg.sv */
// ---------------------------------------------------------------------------
// mbdlp_pkg
// Shared types and constants for the multi-button debouncer with long-press
// detection.
// ---------------------------------------------------------------------------
`default_nettype none

package mbdlp_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned PinW   = 6;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned CfgAw  = 1;
  localparam int unsigned InDw   = 40;
  localparam int unsigned OutDw  = 40;

  // Buttons whose state feeds the combo flags (0-based).
  localparam int unsigned PairA  = 0;
  localparam int unsigned PairB  = 1;
  localparam int unsigned ComboA = 4;
  localparam int unsigned ComboB = 5;

  localparam logic [CfgAw-1:0] RegDebounce  = 1'b0;
  localparam logic [CfgAw-1:0] RegLongPress = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2,
    EV_LONG    = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEB,
    ST_LNG,
    ST_CMB4,
    ST_CMB5,
    ST_FIN
  } state_e;

  // Request to the shared elapsed-time compare unit.
  typedef struct packed {
    logic [TimeW-1:0] base;
    logic [MsW-1:0]   limit;
    logic             incl;
  } tcmp_req_t;

endpackage

`default_nettype wire

/* hdl/mbdlp_tcmp.sv */
// ---------------------------------------------------------------------------
// mbdlp_tcmp
// Shared elapsed-time unit: wrapping subtract of a base time from the poll
// time and compare against a millisecond limit.
// ---------------------------------------------------------------------------
`default_nettype none

module mbdlp_tcmp (
  input  wire logic [mbdlp_pkg::TimeW-1:0] now_i,
  input  wire mbdlp_pkg::tcmp_req_t        req_i,
  output logic                             hit_o
);
  import mbdlp_pkg::*;

  logic [TimeW-1:0] elapsed;
  logic [TimeW-1:0] limit_ext;

  assign elapsed   = now_i - req_i.base;
  assign limit_ext = {{(TimeW-MsW){1'b0}}, req_i.limit};

  // Debounce wants strictly greater, long press wants greater or equal.
  assign hit_o = req_i.incl ? (elapsed >= limit_ext) : (elapsed > limit_ext);

endmodule

`default_nettype wire

/* hdl/multi_button_debounce_long_press.sv */
// ---------------------------------------------------------------------------
// multi_button_debounce_long_press
// Debouncer and long-press detector for a bank of active-low buttons.
// ---------------------------------------------------------------------------
// Each input request is one poll (time in ms and raw pin levels) and yields
// exactly one result request. Buttons are scanned in order and the scan
// stops at the first button with an event. Every scanned button gets a
// debounce check, and a button that is past its debounce time also gets a
// long-press check; the two combo checks and the result hand-off follow. The
// hand-off stalls while an earlier result still waits in the output
// register. The scanner then returns to idle before it can take the next
// poll. The scan is paced by the single shared subtract-and-compare unit,
// which does one elapsed-time check per cycle. The input is accepted only
// while the scanner is idle; a result may still wait in the output register
// at that time.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_button_debounce_long_press #(
  parameter int unsigned NUM_BUTTONS = 6
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port.
  input  wire logic                          cfg_we_i,
  input  wire logic [mbdlp_pkg::CfgAw-1:0]   cfg_addr_i,
  input  wire logic [mbdlp_pkg::MsW-1:0]     cfg_wdata_i,
  // Poll input.
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [31:0] now_ms, [37:32] pin_levels, [39:38] zero
  input  wire logic [mbdlp_pkg::InDw-1:0]    s_axis_tdata_i,
  // Event output.
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [2:0] button_index, [34:3] event_time, [35] pairing_combo,
  // [36] factory_reset_combo, [37] channel_up_combo,
  // [38] channel_down_combo, [39] zero
  output logic [mbdlp_pkg::OutDw-1:0]        m_axis_tdata_o,
  // [1:0] event_kind
  output logic [1:0]                         m_axis_tuser_o
);
  import mbdlp_pkg::*;

  localparam int unsigned BW = $clog2(NUM_BUTTONS);
  localparam logic [BW-1:0] LastBtn = BW'(NUM_BUTTONS - 1);

  state_e state_q, state_d;

  // Configuration registers.
  logic [MsW-1:0] deb_ms_q;
  logic [MsW-1:0] long_ms_q;

  // Per-button state.
  logic [NUM_BUTTONS-1:0] prev_raw_q;
  logic [NUM_BUTTONS-1:0] stable_q;
  logic [NUM_BUTTONS-1:0] long_fired_q;
  logic [TimeW-1:0]       change_time_q [NUM_BUTTONS];
  logic [TimeW-1:0]       press_start_q [NUM_BUTTONS];

  // Poll being scanned and partial result.
  logic [TimeW-1:0] now_q;
  logic [PinW-1:0]  pins_q;
  logic [BW-1:0]    btn_q;
  event_e           ev_q;
  event_e           kind_q;
  logic [IdxW-1:0]  idx_q;
  logic             long4_q;
  logic             long5_q;

  // Output register.
  logic             out_valid_q;
  logic [OutDw-1:0] out_data_q;
  logic [1:0]       out_user_q;

  logic [NUM_BUTTONS-1:0] raw_all;
  logic                   cur_raw;
  logic                   chg;
  logic [TimeW-1:0]       ct_eff;
  tcmp_req_t              req;
  logic                   hit;
  event_e                 deb_ev;
  logic                   long_ok;
  event_e                 ev_fin;
  logic                   is_last;
  logic [BW:0]            btn_inc;
  logic                   accept;
  logic                   out_free;
  logic                   deb_wr;
  logic                   lng_wr;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_raw
    if (i < PinW) begin : g_pin
      assign raw_all[i] = pins_q[i];
    end else begin : g_none
      assign raw_all[i] = 1'b1;
    end
  end

  assign cur_raw  = raw_all[btn_q];
  assign chg      = cur_raw != prev_raw_q[btn_q];
  assign ct_eff   = chg ? now_q : change_time_q[btn_q];
  assign is_last  = btn_q == LastBtn;
  assign btn_inc  = {1'b0, btn_q} + {{BW{1'b0}}, 1'b1};
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Operand select for the shared unit.
  always_comb begin
    req = '{base: press_start_q[btn_q], limit: long_ms_q, incl: 1'b1};
    unique case (state_q)
      ST_DEB:  req = '{base: ct_eff, limit: deb_ms_q, incl: 1'b0};
      ST_CMB4: req = '{base: press_start_q[ComboA], limit: long_ms_q, incl: 1'b1};
      ST_CMB5: req = '{base: press_start_q[ComboB], limit: long_ms_q, incl: 1'b1};
      default: ;
    endcase
  end

  mbdlp_tcmp u_tcmp (
    .now_i (now_q),
    .req_i (req),
    .hit_o (hit)
  );

  // Event from accepting a new stable level.
  always_comb begin
    deb_ev = EV_NONE;
    if (cur_raw != stable_q[btn_q]) begin
      if (!cur_raw) begin
        deb_ev = EV_PRESS;
      end else if (!long_fired_q[btn_q]) begin
        deb_ev = EV_RELEASE;
      end
    end
  end

  assign long_ok = !stable_q[btn_q] && !long_fired_q[btn_q] &&
                   (press_start_q[btn_q] != '0) && hit;
  assign ev_fin  = long_ok ? EV_LONG : ev_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid_i) state_d = ST_DEB;
      ST_DEB: begin
        if (hit) begin
          state_d = ST_LNG;
        end else if (is_last) begin
          state_d = ST_CMB4;
        end
      end
      ST_LNG: begin
        if (ev_fin != EV_NONE || is_last) begin
          state_d = ST_CMB4;
        end else begin
          state_d = ST_DEB;
        end
      end
      ST_CMB4: state_d = ST_CMB5;
      ST_CMB5: state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    s_axis_tready_o = 1'b0;
    deb_wr          = 1'b0;
    lng_wr          = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_DEB:  deb_wr = 1'b1;
      ST_LNG:  lng_wr = long_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ms_q  <= MsW'(50);
      long_ms_q <= MsW'(1000);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegDebounce:  deb_ms_q  <= cfg_wdata_i;
        RegLongPress: long_ms_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Button state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_raw_q   <= '1;
      stable_q     <= '1;
      long_fired_q <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        change_time_q[i] <= '0;
        press_start_q[i] <= '0;
      end
    end else begin
      if (deb_wr) begin
        prev_raw_q[btn_q]    <= cur_raw;
        change_time_q[btn_q] <= ct_eff;
        if (hit && (cur_raw != stable_q[btn_q])) begin
          stable_q[btn_q] <= cur_raw;
          if (!cur_raw) begin
            press_start_q[btn_q] <= now_q;
            long_fired_q[btn_q]  <= 1'b0;
          end else begin
            press_start_q[btn_q] <= '0;
          end
        end
      end
      if (lng_wr) begin
        long_fired_q[btn_q] <= 1'b1;
      end
    end
  end

  // Scan bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_q   <= '0;
      ev_q    <= EV_NONE;
      kind_q  <= EV_NONE;
      idx_q   <= '0;
      long4_q <= 1'b0;
      long5_q <= 1'b0;
    end else begin
      if (accept) begin
        btn_q  <= '0;
        kind_q <= EV_NONE;
        idx_q  <= '0;
      end
      if (state_q == ST_DEB) begin
        ev_q <= hit ? deb_ev : EV_NONE;
        if (!hit && !is_last) begin
          btn_q <= btn_inc[BW-1:0];
        end
      end
      if (state_q == ST_LNG) begin
        if (ev_fin != EV_NONE) begin
          kind_q <= ev_fin;
          idx_q  <= btn_inc[IdxW-1:0];
        end else if (!is_last) begin
          btn_q <= btn_inc[BW-1:0];
        end
      end
      if (state_q == ST_CMB4) long4_q <= !stable_q[ComboA] && hit;
      if (state_q == ST_CMB5) long5_q <= !stable_q[ComboB] && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q  <= s_axis_tdata_i[TimeW-1:0];
      pins_q <= s_axis_tdata_i[TimeW +: PinW];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      out_user_q <= kind_q;
      out_data_q <= {1'b0,
                     long5_q && stable_q[ComboA],
                     long4_q && stable_q[ComboB],
                     long4_q && long5_q,
                     !stable_q[PairA] && !stable_q[PairB],
                     (kind_q != EV_NONE) ? now_q : {TimeW{1'b0}},
                     idx_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef ASSERT_OFF
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_DEB && btn_q == '0))
    else $error("scan did not start at the first button");

  a_btn_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEB || state_q == ST_LNG) |-> (btn_q <= LastBtn))
    else $error("button counter out of range");

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !m_axis_tready_i) |=> state_q == ST_FIN)
    else $error("result overwrote a pending output");

  a_none_has_no_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_user_q == EV_NONE) == (out_data_q[IdxW-1:0] == '0)))
    else $error("event kind and button index disagree");
`endif

endmodule

`default_nettype wire

/* verif/multi_button_debounce_long_press_tb.sv */
// ---------------------------------------------------------------------------
// multi_button_debounce_long_press_tb
// Self-checking testbench for the six-button debouncer with long-press
// detection. Polls are sent over the input stream, and a behavioral
// predictor works out the event and combo flags that each poll must produce.
// Every result request is checked field by field against the oldest
// prediction. Directed tests cover debounce, long press, scan order, combos,
// a press that starts at time zero and the register extremes. Random phases
// follow, with extreme or random settings and random gaps on both streams.
// ---------------------------------------------------------------------------
`default_nettype none

module multi_button_debounce_long_press_tb;
  import mbdlp_pkg::*;

  localparam int unsigned NumBtn = 6;

  typedef struct packed {
    event_e           kind;
    logic [IdxW-1:0]  button;
    logic [TimeW-1:0] stamp;
    logic             pairing;
    logic             factory_reset;
    logic             channel_up;
    logic             channel_down;
  } outcome_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                cfg_we_i        = 1'b0;
  logic [CfgAw-1:0]    cfg_addr_i      = RegDebounce;
  logic [MsW-1:0]      cfg_wdata_i     = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDw-1:0]     s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDw-1:0]    m_axis_tdata_o;
  logic [1:0]          m_axis_tuser_o;

  // Predicted button bank and timing registers.
  logic                last_raw   [NumBtn];
  logic                stable_lvl [NumBtn];
  logic [TimeW-1:0]    raw_change [NumBtn];
  logic [TimeW-1:0]    hold_start [NumBtn];
  logic                long_done  [NumBtn];
  logic [MsW-1:0]      debounce_setting;
  logic [MsW-1:0]      long_setting;

  outcome_t            pending_events[$];
  int unsigned         mismatches  = 0;
  bit                  steady_flow = 1'b0;

  multi_button_debounce_long_press #(
    .NUM_BUTTONS(NumBtn)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void reset_bank();
    debounce_setting = 16'd50;
    long_setting     = 16'd1000;
    for (int b = 0; b < NumBtn; b++) begin
      last_raw[b]   = 1'b1;
      stable_lvl[b] = 1'b1;
      raw_change[b] = '0;
      hold_start[b] = '0;
      long_done[b]  = 1'b0;
    end
  endfunction

  function automatic logic held_long(input int unsigned b, input logic [TimeW-1:0] t);
    logic [TimeW-1:0] held;
    held = t - hold_start[b];
    return !stable_lvl[b] && (held >= TimeW'(long_setting));
  endfunction

  function automatic outcome_t predict_poll(input logic [TimeW-1:0] t,
                                            input logic [PinW-1:0] pins);
    outcome_t         res;
    event_e           ev;
    logic             raw;
    logic             found;
    logic [TimeW-1:0] steady;
    res   = '0;
    found = 1'b0;
    for (int b = 0; b < NumBtn && !found; b++) begin
      raw = pins[b];
      ev  = EV_NONE;
      if (raw != last_raw[b]) raw_change[b] = t;
      steady = t - raw_change[b];
      if (steady > TimeW'(debounce_setting)) begin
        if (raw != stable_lvl[b]) begin
          stable_lvl[b] = raw;
          if (!raw) begin
            hold_start[b] = t;
            long_done[b]  = 1'b0;
            ev            = EV_PRESS;
          end else begin
            // A release after a long press stays silent.
            if (!long_done[b]) ev = EV_RELEASE;
            hold_start[b] = '0;
          end
        end
        if (!stable_lvl[b] && !long_done[b] && hold_start[b] != '0 &&
            (t - hold_start[b]) >= TimeW'(long_setting)) begin
          long_done[b] = 1'b1;
          ev           = EV_LONG;
        end
      end
      last_raw[b] = raw;
      if (ev != EV_NONE) begin
        res.kind   = ev;
        res.button = IdxW'(b + 1);
        res.stamp  = t;
        found      = 1'b1;
      end
    end
    res.pairing       = !stable_lvl[PairA] && !stable_lvl[PairB];
    res.factory_reset = held_long(ComboA, t) && held_long(ComboB, t);
    res.channel_up    = held_long(ComboA, t) && stable_lvl[ComboB];
    res.channel_down  = held_long(ComboB, t) && stable_lvl[ComboA];
    return res;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  task automatic check_event();
    outcome_t want;
    if (pending_events.size() == 0) begin
      $error("event request with no poll outstanding: kind %0d, button %0d",
             m_axis_tuser_o, m_axis_tdata_o[2:0]);
      mismatches++;
    end else begin
      want = pending_events.pop_front();
      compare_field("event_kind", 32'(want.kind), 32'(m_axis_tuser_o));
      compare_field("button_index", 32'(want.button), 32'(m_axis_tdata_o[2:0]));
      compare_field("event_time", want.stamp, m_axis_tdata_o[34:3]);
      compare_field("pairing_combo", 32'(want.pairing), 32'(m_axis_tdata_o[35]));
      compare_field("factory_reset_combo", 32'(want.factory_reset),
                    32'(m_axis_tdata_o[36]));
      compare_field("channel_up_combo", 32'(want.channel_up), 32'(m_axis_tdata_o[37]));
      compare_field("channel_down_combo", 32'(want.channel_down),
                    32'(m_axis_tdata_o[38]));
    end
  endtask

  // Event sink with random back-pressure.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) check_event();
      m_axis_tready_i <= steady_flow || ($urandom_range(99) >= 15);
    end
  end

  // Valid stays high between back-to-back polls; it only drops for a gap.
  task automatic send_poll(input logic [TimeW-1:0] t, input logic [PinW-1:0] pins);
    if (!steady_flow && $urandom_range(99) < 15) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, pins, t};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_events.push_back(predict_poll(t, pins));
  endtask

  task automatic drain_events();
    s_axis_tvalid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_timing(input logic [MsW-1:0] deb, input logic [MsW-1:0] hold);
    drain_events();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= RegDebounce;
    cfg_wdata_i <= deb;
    @(posedge clk_i);
    cfg_addr_i  <= RegLongPress;
    cfg_wdata_i <= hold;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    debounce_setting = deb;
    long_setting     = hold;
  endtask

  // Reset timing: press on button one, long press, then a silent release.
  task automatic test_debounce_and_long_press();
    send_poll(32'd0, 6'h3E);
    send_poll(32'd50, 6'h3E);
    send_poll(32'd51, 6'h3E);
    send_poll(32'd1051, 6'h3E);
    send_poll(32'd1100, 6'h3F);
    send_poll(32'd1151, 6'h3F);
  endtask

  // Button three is accepted at time zero and must never fire a long press.
  task automatic test_zero_press_start();
    set_timing(16'd0, 16'hFFFF);
    send_poll(32'hFFFF_FFF0, 6'h2B);
    send_poll(32'd0, 6'h2B);
    send_poll(32'd1, 6'h2B);
    send_poll(32'd70000, 6'h2B);
    send_poll(32'd70001, 6'h3F);
    send_poll(32'd70002, 6'h3F);
    send_poll(32'd70003, 6'h3F);
  endtask

  // Four buttons pressed at once report one per poll, then the combos.
  task automatic test_scan_order_and_combos();
    set_timing(16'd50, 16'd1000);
    send_poll(32'd5000, 6'h0C);
    for (int k = 0; k < 4; k++) send_poll(32'd5100 + k, 6'h0C);
    for (int k = 0; k < 4; k++) send_poll(32'd7000 + k, 6'h0C);
    send_poll(32'd7100, 6'h1C);
    send_poll(32'd7200, 6'h1C);
  endtask

  // Longest debounce with a zero hold time: the long press replaces the
  // press on the same poll, except for a press that starts at time zero.
  task automatic test_register_extremes();
    set_timing(16'hFFFF, 16'd0);
    send_poll(32'hFFFE_FFFF, 6'h00);
    send_poll(32'hFFFF_FFFF, 6'h00);
    send_poll(32'd0, 6'h00);
  endtask

  task automatic test_random_polls();
    logic [TimeW-1:0] clock_ms;
    logic [PinW-1:0]  pins;
    logic [MsW-1:0]   deb;
    logic [MsW-1:0]   hold;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          deb  = 16'd0;
          hold = 16'd0;
        end
        1: begin
          deb  = 16'hFFFF;
          hold = 16'hFFFF;
        end
        default: begin
          deb  = MsW'($urandom_range(0, 30));
          hold = MsW'($urandom_range(0, 300));
        end
      endcase
      set_timing(deb, hold);
      steady_flow = (phase == 4);
      clock_ms    = $urandom;
      pins        = 6'h3F;
      for (int n = 0; n < 85; n++) begin
        if ($urandom_range(99) < 5) begin
          // Occasional jump in time with arbitrary pin levels.
          clock_ms = $urandom;
          pins     = PinW'($urandom);
        end else begin
          clock_ms = clock_ms + $urandom_range(0, 2 * deb + 10);
          for (int b = 0; b < NumBtn; b++)
            if ($urandom_range(99) < 12) pins[b] = ~pins[b];
        end
        send_poll(clock_ms, pins);
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    reset_bank();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_debounce_and_long_press();
    test_zero_press_start();
    test_scan_order_and_combos();
    test_register_extremes();
    test_random_polls();
    drain_events();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
